>>> sv/cdchunk_pkg.sv
// Shared constants, types and elaboration-time tables for the content-defined chunker.
`default_nettype none

package cdchunk_pkg;

	// Configuration register indices
	localparam logic [1:0] REG_MIN_LEN       = 2'd0;
	localparam logic [1:0] REG_MAX_LEN       = 2'd1;
	localparam logic [1:0] REG_BOUNDARY_MASK = 2'd2;

	localparam int unsigned LEN_W  = 17;
	localparam int unsigned MASK_W = 32;
	localparam int unsigned WRAP_W = 64;
	localparam int unsigned PRIME_W = 30;
	localparam int unsigned OUT_TDATA_W = 112;

	localparam logic [LEN_W-1:0]  MIN_LEN_RST       = 17'd4096;
	localparam logic [LEN_W-1:0]  MAX_LEN_RST       = 17'd65536;
	localparam logic [MASK_W-1:0] BOUNDARY_MASK_RST = 32'd16383;

	localparam longint unsigned ROLL_BASE = 64'd257;
	localparam longint unsigned PRIME_MOD = 64'd998244353;
	localparam logic [30:0] PRIME_MOD_X1 = 31'd998244353;
	localparam logic [30:0] PRIME_MOD_X2 = 31'd1996488706;

	// Folding table: entry i holds (i * 2^30) mod PRIME_MOD
	localparam int unsigned FOLD_DEPTH = 128;
	typedef logic [PRIME_W-1:0] fold_tbl_t [FOLD_DEPTH];

	function automatic fold_tbl_t build_fold();
		fold_tbl_t       tbl;
		longint unsigned v;
		for (int i = 0; i < FOLD_DEPTH; i++) begin
			v = (longint'(i) << 30) % PRIME_MOD;
			tbl[i] = v[PRIME_W-1:0];
		end
		return tbl;
	endfunction

	localparam fold_tbl_t FOLD_TBL = build_fold();

	// 257^n mod 2^64
	function automatic logic [WRAP_W-1:0] window_power(input int unsigned n);
		logic [WRAP_W-1:0] p;
		p = 64'd1;
		for (int unsigned i = 0; i < n; i++) begin
			p = p * ROLL_BASE;
		end
		return p;
	endfunction

endpackage

`default_nettype wire

>>> sv/cdchunk_prime_step.sv
// One step of the base-131 chunk hash, reduced modulo 998244353.
`default_nettype none

module cdchunk_prime_step (
	input  wire logic [cdchunk_pkg::PRIME_W-1:0] hash_in,   // must be below the modulus
	input  wire logic [7:0]                      data_byte,
	output logic      [cdchunk_pkg::PRIME_W-1:0] hash_out
);
	import cdchunk_pkg::*;

	logic [36:0] prod;
	logic [30:0] folded;
	logic [30:0] minus1;
	logic [30:0] minus2;

	// h*131 + b stays below 2^37, so the top seven bits fold through the table
	assign prod   = ({hash_in, 7'd0} + {6'd0, hash_in, 1'b0}) + {7'd0, hash_in}
	                + {29'd0, data_byte};
	assign folded = {1'b0, FOLD_TBL[prod[36:30]]} + {1'b0, prod[29:0]};
	assign minus1 = folded - PRIME_MOD_X1;
	assign minus2 = folded - PRIME_MOD_X2;

	// folded is below 3M: at most two subtractions
	always_comb begin
		if (folded >= PRIME_MOD_X2) begin
			hash_out = minus2[PRIME_W-1:0];
		end else if (folded >= PRIME_MOD_X1) begin
			hash_out = minus1[PRIME_W-1:0];
		end else begin
			hash_out = folded[PRIME_W-1:0];
		end
	end

endmodule

`default_nettype wire

>>> sv/content_defined_chunker_unit.sv
// Top level of the content-defined chunker: byte stream in, one request per closed chunk out.
`default_nettype none

// Content-defined chunker. Takes one byte per request and cuts the stream into chunks
// whose boundaries follow the data: a rolling hash (base 257, mod 2^64) over the last
// WINDOW_BYTES bytes is tested against boundary_mask once the chunk holds the configured
// minimum length; reaching the configured maximum length forces a cut, a chunk never
// exceeds CHUNK_LIMIT bytes, and a byte with tlast set always closes the chunk. Each
// closed chunk yields one output request with its length, a base-257 hash mod 2^64, a
// base-131 hash mod 998244353, and tlast set when the chunk was closed by end of stream.
// Window, rolling hash and chunk hashes restart after every cut. Throughput is one byte
// per clock while the output is not held: the whole per-byte update (shift-add hashes,
// constant-modulus fold, cut decision) sits between the input stage register and the
// output register. The input stalls only while an output request is held and not
// taken. No clearing pass after reset. Configuration writes must be made while the
// block is idle.
module content_defined_chunker_unit #(
	parameter int unsigned WINDOW_BYTES = 48,
	parameter int unsigned CHUNK_LIMIT  = 65536
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration
	input  wire logic                                  cfg_we,
	input  wire logic [1:0]                            cfg_index,
	input  wire logic [cdchunk_pkg::MASK_W-1:0]        cfg_data,
	// byte stream in
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	input  wire logic [7:0]                            s_axis_tdata,   // [7:0] data_byte
	input  wire logic                                  s_axis_tlast,   // end_of_stream
	// chunk results out
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// [16:0] chunk_length, [80:17] chunk_hash_wrap, [110:81] chunk_hash_prime, [111] zero
	output logic [cdchunk_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
	output logic                                       m_axis_tlast    // stream_end
);
	import cdchunk_pkg::*;

	localparam int unsigned FILL_W = $clog2(WINDOW_BYTES + 1);
	localparam int unsigned CNT_W  = $clog2(CHUNK_LIMIT + 1);
	localparam int unsigned CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam logic [WRAP_W-1:0] WIN_POW = window_power(WINDOW_BYTES);

	// configuration registers
	logic [LEN_W-1:0]  min_len_q;
	logic [LEN_W-1:0]  max_len_q;
	logic [MASK_W-1:0] boundary_mask_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// chunk state
	logic [7:0]         win_q [WINDOW_BYTES];
	logic [FILL_W-1:0]  fill_q;
	logic [WRAP_W-1:0]  roll_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [WRAP_W-1:0]  wrap_q;
	logic [PRIME_W-1:0] prime_q;

	// output register
	logic               out_valid_q;
	logic [LEN_W-1:0]   out_len_q;
	logic [WRAP_W-1:0]  out_wrap_q;
	logic [PRIME_W-1:0] out_prime_q;
	logic               out_end_q;

	// next-state logic
	logic               adv;
	logic               win_full;
	logic [7:0]         leave_byte;
	logic [WRAP_W-1:0]  leave_term;
	logic [WRAP_W-1:0]  roll_new;
	logic [WRAP_W-1:0]  wrap_new;
	logic [PRIME_W-1:0] prime_new;
	logic [CNT_W-1:0]   len_new;
	logic [FILL_W-1:0]  fill_new;
	logic               len_min_ok;
	logic               cut;

	// The stage moves whenever the output register is free or being emptied
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q       <= MIN_LEN_RST;
			max_len_q       <= MAX_LEN_RST;
			boundary_mask_q <= BOUNDARY_MASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_LEN:       min_len_q       <= cfg_data[LEN_W-1:0];
				REG_MAX_LEN:       max_len_q       <= cfg_data[LEN_W-1:0];
				REG_BOUNDARY_MASK: boundary_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			eos_s1  <= s_axis_tlast;
		end
	end

	// Window: shift line, oldest byte at the far end. Contents are only read once
	// the fill count says every tap holds a byte of the current chunk.
	assign win_full   = (fill_q == FILL_W'(WINDOW_BYTES));
	assign leave_byte = win_full ? win_q[WINDOW_BYTES-1] : 8'd0;
	assign fill_new   = win_full ? fill_q : FILL_W'(fill_q + 1'b1);

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			win_q[0] <= byte_s1;
			for (int i = 1; i < WINDOW_BYTES; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	// leaving byte times 257^W, as eight shifted partial terms
	always_comb begin
		leave_term = '0;
		for (int i = 0; i < 8; i++) begin
			if (leave_byte[i]) begin
				leave_term = leave_term + (WIN_POW << i);
			end
		end
	end

	assign roll_new = ({roll_q[WRAP_W-9:0], 8'd0} + roll_q) + {56'd0, byte_s1} - leave_term;
	assign wrap_new = ({wrap_q[WRAP_W-9:0], 8'd0} + wrap_q) + {56'd0, byte_s1};

	cdchunk_prime_step u_prime (
		.hash_in   (prime_q),
		.data_byte (byte_s1),
		.hash_out  (prime_new)
	);

	// length saturates at the limit; reaching it always cuts
	assign len_new    = (cnt_q < CNT_W'(CHUNK_LIMIT)) ? CNT_W'(cnt_q + 1'b1) : cnt_q;
	assign len_min_ok = CMP_W'(len_new) >= CMP_W'(min_len_q);
	assign cut = (len_min_ok && (((roll_new[MASK_W-1:0] & boundary_mask_q) == '0) ||
	              (CMP_W'(len_new) >= CMP_W'(max_len_q))))
	             || (len_new >= CNT_W'(CHUNK_LIMIT)) || eos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			roll_q  <= '0;
			cnt_q   <= '0;
			wrap_q  <= '0;
			prime_q <= '0;
		end else if (valid_s1 && adv) begin
			if (cut) begin
				fill_q  <= '0;
				roll_q  <= '0;
				cnt_q   <= '0;
				wrap_q  <= '0;
				prime_q <= '0;
			end else begin
				fill_q  <= fill_new;
				roll_q  <= roll_new;
				cnt_q   <= len_new;
				wrap_q  <= wrap_new;
				prime_q <= prime_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && cut;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && cut) begin
			out_len_q   <= LEN_W'(len_new);
			out_wrap_q  <= wrap_new;
			out_prime_q <= prime_new;
			out_end_q   <= eos_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_prime_q, out_wrap_q, out_len_q};
	assign m_axis_tlast  = out_end_q;

`ifndef ASSERT_OFF
	// the stored length is always below the limit: reaching it cuts and clears
	a_cnt_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(CHUNK_LIMIT))
		else $error("chunk byte count reached the limit without a cut");

	// the running prime hash stays reduced
	a_prime_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		prime_q < PRIME_W'(PRIME_MOD))
		else $error("running prime hash not reduced");

	// an end-of-stream byte leaves the chunk state fully cleared
	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv && eos_s1) |=> (cnt_q == '0 && fill_q == '0 && roll_q == '0))
		else $error("chunk state not cleared after end of stream");

	// a result request is raised only by a processed byte
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && adv))
		else $error("result raised without a processed byte");
`endif

endmodule

`default_nettype wire
